// ----- sv/pct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the particle class table.
package pct_pkg;

  localparam int CLASS_MAX = 256;
  localparam int IDX_W     = (CLASS_MAX > 1) ? $clog2(CLASS_MAX) : 1;
  localparam int CNT_W     = $clog2(CLASS_MAX + 1);

  localparam int ORDER_W   = 40;
  localparam int VAL_W     = 32;
  localparam int CLS_OUT_W = 8;
  localparam int IN_W      = ORDER_W + 2 * VAL_W;          // 104, whole bytes
  localparam int OUT_W     = CLS_OUT_W + 2 * VAL_W;        // 72, whole bytes
  localparam int USER_W    = 4;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 64;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_WINDOW = 3'd1,
    ERR_SIGN   = 3'd2,
    ERR_FULL   = 3'd3,
    ERR_UNEXP  = 3'd4
  } err_t;

  typedef enum logic {
    REG_FIRST = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic check;
    logic srch_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err_any;
    logic hit;
    logic miss_end;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [ORDER_W-1:0] first_order;
    logic [VAL_W-1:0]   order_count;
    logic               load_count;
  } cfg_t;

  typedef struct packed {
    logic [ORDER_W-1:0] high;
    logic [ORDER_W-1:0] low;
    logic [VAL_W-1:0]   softening;
    logic [VAL_W-1:0]   mass;
  } entry_t;

  // strictly positive: sign clear, non-zero, not NaN (inf and denormals pass)
  function automatic logic is_positive(input logic [VAL_W-1:0] bits);
    logic nan;
    nan = (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
    return !bits[31] && (bits != '0) && !nan;
  endfunction

endpackage

// ----- sv/pct_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for accept, check, table search and commit.
module pct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pct_pkg::dp_stat_t   stat,
  output pct_pkg::ctrl_cmd_t  cmd
);
  import pct_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = stat.err_any ? S_COMMIT : S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.hit || stat.miss_end) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      S_CHECK:  cmd.check     = 1'b1;
      S_SEARCH: cmd.srch_step = 1'b1;
      S_COMMIT: cmd.commit    = stat.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/pct_dpath.sv -----
`timescale 1ns / 1ps
// Class table memory, window checks, search pipeline and result register.
module pct_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pct_pkg::IN_W-1:0]      in_tdata,
  input  pct_pkg::cfg_t                 cfg,
  input  pct_pkg::ctrl_cmd_t            cmd,
  output pct_pkg::dp_stat_t             stat,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [pct_pkg::OUT_W-1:0]     out_tdata,
  output logic [pct_pkg::USER_W-1:0]    out_tuser
);
  import pct_pkg::*;

  logic [ORDER_W-1:0] order_r;
  logic [VAL_W-1:0]   mass_r, soft_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      order_r <= in_tdata[ORDER_W-1:0];
      mass_r  <= in_tdata[ORDER_W +: VAL_W];
      soft_r  <= in_tdata[ORDER_W+VAL_W +: VAL_W];
    end
  end

  // ---------------- admission checks ----------------
  logic [VAL_W-1:0]   expected_r, expected_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [ORDER_W:0]   diff_w;
  logic               win_bad_w;
  err_t               err_w, err_r;
  logic [VAL_W-1:0]   local_r;

  assign diff_w    = {1'b0, order_r} - {1'b0, cfg.first_order};
  assign win_bad_w = diff_w[ORDER_W] ||
                     (diff_w[ORDER_W-1:0] >= {{(ORDER_W-VAL_W){1'b0}}, cfg.order_count});

  always_comb begin
    if (expected_r == '0) begin
      err_w = ERR_UNEXP;
    end else if (win_bad_w) begin
      err_w = ERR_WINDOW;
    end else if (!is_positive(mass_r) || !is_positive(soft_r)) begin
      err_w = ERR_SIGN;
    end else begin
      err_w = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      err_r   <= err_w;
      local_r <= diff_w[VAL_W-1:0];
    end
  end

  // Search issues one read per cycle and compares the read data in the next cycle.
  entry_t             class_mem [CLASS_MAX];
  entry_t             rd_data_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_vld_r;
  logic               found_r;
  logic               hit_w, more_w, rd_en_w;
  logic               wr_en_w;
  logic [IDX_W-1:0]   wr_addr_w;
  entry_t             wr_data_w;

  assign hit_w   = cmp_vld_r && (rd_data_r.mass == mass_r) && (rd_data_r.softening == soft_r);
  assign more_w  = (rd_idx_r != total_r);
  assign rd_en_w = cmd.srch_step && !hit_w && more_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.check) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.srch_step) begin
      if (hit_w) begin
        found_r   <= 1'b1;
      end else begin
        cmp_vld_r <= more_w;
        if (more_w) rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_w) begin
      rd_data_r <= class_mem[rd_idx_r[IDX_W-1:0]];
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (wr_en_w) begin
      class_mem[wr_addr_w] <= wr_data_w;
    end
  end

  assign stat.err_any  = (err_w != ERR_NONE);
  assign stat.hit      = hit_w;
  assign stat.miss_end = !cmp_vld_r && !more_w;

  // ---------------- commit ----------------
  entry_t             upd_w, fresh_w;
  logic               full_w;
  err_t               res_err;
  logic [IDX_W-1:0]   res_cls;
  logic               res_new;
  logic [VAL_W-1:0]   res_local;
  logic [VAL_W-1:0]   res_left;

  assign full_w = (total_r == CNT_W'(CLASS_MAX));

  always_comb begin
    upd_w = rd_data_r;
    if (rd_data_r.high < order_r) begin
      upd_w.high = order_r;
    end else if (rd_data_r.low > order_r) begin
      upd_w.low = order_r;
    end
  end

  assign fresh_w = '{high: order_r, low: order_r, softening: soft_r, mass: mass_r};

  always_comb begin
    wr_en_w   = 1'b0;
    wr_addr_w = cmp_idx_r;
    wr_data_w = upd_w;
    res_err   = err_r;
    res_cls   = '0;
    res_new   = 1'b0;
    res_local = '0;
    res_left  = expected_r;
    total_nxt = total_r;
    if (err_r != ERR_NONE) begin
      res_err = err_r;
    end else if (found_r) begin
      wr_en_w   = cmd.commit;
      res_cls   = cmp_idx_r;
      res_local = local_r;
      res_left  = expected_r - VAL_W'(1);
    end else if (full_w) begin
      res_err   = ERR_FULL;
    end else begin
      wr_en_w   = cmd.commit;
      wr_addr_w = total_r[IDX_W-1:0];
      wr_data_w = fresh_w;
      res_cls   = total_r[IDX_W-1:0];
      res_new   = 1'b1;
      res_local = local_r;
      res_left  = expected_r - VAL_W'(1);
      total_nxt = total_r + CNT_W'(1);
    end
  end

  always_comb begin
    expected_nxt = expected_r;
    if (cfg.load_count) begin
      expected_nxt = cfg.order_count;
    end else if (cmd.commit) begin
      expected_nxt = res_left;
    end
  end

  logic out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r   <= '0;
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      expected_r <= expected_nxt;
      if (cmd.commit) begin
        total_r      <= total_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata <= {res_left, res_local, CLS_OUT_W'(res_cls)};
      out_tuser <= {res_err, res_new};
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign stat.out_free = !out_tvalid_r || out_tready;

endmodule

// ----- sv/particle_class_table_unit.sv -----
`timescale 1ns / 1ps
// A transaction is accepted only in the idle state and passes through check, search and commit;
// a rejected one goes from check straight to commit. No new item is taken until the last is
// committed. The search scans one entry per cycle through the single read port and stops on
// a match; a result still waiting on out_tready holds the next commit back. Reset (synchronous,
// rst_n low) empties the table, clears the expected count and the configuration registers; no
// clearing pass.
module particle_class_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // particle_order[39:0], mass_bits[71:40], soft_bits[103:72]
  input  logic [pct_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // class_index[7:0], local_index[39:8], items_left[71:40]
  output logic [pct_pkg::OUT_W-1:0]     out_tdata,
  // new_class[0], error_code[3:1]
  output logic [pct_pkg::USER_W-1:0]    out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pct_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [pct_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [pct_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import pct_pkg::*;

  logic [ORDER_W-1:0] first_order_r;
  logic [VAL_W-1:0]   order_count_r;
  logic               cfg_wr;
  reg_idx_t           reg_sel;
  cfg_t               cfg;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = reg_idx_t'(cfg_paddr[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_order_r <= '0;
      order_count_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FIRST: first_order_r <= cfg_pwdata[ORDER_W-1:0];
        REG_COUNT: order_count_r <= cfg_pwdata[VAL_W-1:0];
        default:   first_order_r <= first_order_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FIRST: cfg_prdata = {{(CFG_DW-ORDER_W){1'b0}}, first_order_r};
      REG_COUNT: cfg_prdata = {{(CFG_DW-VAL_W){1'b0}}, order_count_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // a count write also reloads the number of items still expected
  assign cfg.first_order = first_order_r;
  assign cfg.order_count = cfg_wr ? cfg_pwdata[VAL_W-1:0] : order_count_r;
  assign cfg.load_count  = cfg_wr && (reg_sel == REG_COUNT);

  pct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pct_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- test/tb_particle_class_table_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for particle_class_table_unit: directed and random particle streams.
module tb_particle_class_table_unit;
  import pct_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam logic [39:0] ORDER_TOP   = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [VAL_W-1:0]   mass;
    logic [VAL_W-1:0]   softening;
  } particle_t;

  typedef struct packed {
    logic [7:0]  cls;
    logic [31:0] local_idx;
    logic        new_flag;
    err_t        err;
    logic [31:0] left;
  } class_tag_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  particle_class_table_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predicted table contents and registers
  logic [VAL_W-1:0]   tbl_mass [CLASS_MAX];
  logic [VAL_W-1:0]   tbl_soft [CLASS_MAX];
  logic [ORDER_W-1:0] tbl_low  [CLASS_MAX];
  logic [ORDER_W-1:0] tbl_high [CLASS_MAX];
  int unsigned        tbl_used;
  logic [31:0]        left_count;
  logic [ORDER_W-1:0] cfg_first;
  logic [31:0]        cfg_count;

  particle_t    queued_particles[$];
  class_tag_t   predicted_tags[$];
  logic [63:0]  known_pairs[$];
  particle_t    cur_particle;
  int unsigned  particles_queued;
  int unsigned  particles_sent;
  int unsigned  cycle_count;
  int           idle_pct;
  int           in_gap;
  int           out_gap;
  bit           in_took;
  bit           failed;

  function automatic bit positive_val(logic [31:0] v);
    bit is_nan;
    is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    return !v[31] && (v != 32'd0) && !is_nan;
  endfunction

  function automatic class_tag_t intern_particle(particle_t p);
    class_tag_t         r;
    logic [ORDER_W-1:0] offs;
    int unsigned        slot;
    int unsigned        i;
    r    = '0;
    offs = p.order - cfg_first;
    slot = tbl_used;
    if (left_count == 32'd0) begin
      r.err = ERR_UNEXP;
    end else if (p.order < cfg_first || offs >= {8'd0, cfg_count}) begin
      r.err = ERR_WINDOW;
    end else if (!positive_val(p.mass) || !positive_val(p.softening)) begin
      r.err = ERR_SIGN;
    end else begin
      for (i = 0; i < tbl_used; i++)
        if (slot == tbl_used && tbl_mass[i] == p.mass && tbl_soft[i] == p.softening) slot = i;
      if (slot < tbl_used) begin
        if (tbl_high[slot] < p.order) tbl_high[slot] = p.order;
        else if (tbl_low[slot] > p.order) tbl_low[slot] = p.order;
      end else if (tbl_used >= CLASS_MAX) begin
        r.err = ERR_FULL;
      end else begin
        tbl_mass[slot] = p.mass;
        tbl_soft[slot] = p.softening;
        tbl_low[slot]  = p.order;
        tbl_high[slot] = p.order;
        tbl_used++;
        r.new_flag = 1'b1;
      end
      if (r.err == ERR_NONE) begin
        r.cls       = 8'(slot);
        r.local_idx = offs[31:0];
        left_count--;
      end
    end
    r.left = left_count;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_positive();
    logic [31:0] v;
    v = $urandom & 32'h7FFF_FFFF;
    if (v[30:23] == 8'hFF) v[22:0] = '0;
    if (v == 32'd0) v = 32'd1;
    return v;
  endfunction

  function automatic logic [ORDER_W-1:0] order_in_window();
    logic [63:0] room;
    room = {24'd0, ORDER_TOP - cfg_first};
    if (room > {32'd0, cfg_count} - 64'd1) room = {32'd0, cfg_count} - 64'd1;
    return cfg_first + $urandom_range(0, 32'(room));
  endfunction

  function automatic bit field_ok(string name, longint unsigned want, longint unsigned got);
    if (want != got) $error("%s: expected %0d, got %0d", name, want, got);
    return want == got;
  endfunction

  task automatic push_particle(logic [ORDER_W-1:0] o, logic [31:0] m, logic [31:0] s);
    particle_t p;
    p.order     = o;
    p.mass      = m;
    p.softening = s;
    queued_particles.push_back(p);
    particles_queued++;
  endtask

  task automatic queue_random(int n, int fresh_pct);
    particle_t   p;
    logic [63:0] pair;
    @(posedge clk);
    repeat (n) begin
      if (cfg_count != 32'd0) p.order = order_in_window();
      else p.order = ORDER_W'({$urandom, $urandom});
      if ($urandom_range(0, 99) < fresh_pct || known_pairs.size() == 0) begin
        p.mass = rand_positive();
        // sometimes reuse a known mass so that only the softening tells them apart
        if ($urandom_range(0, 3) == 0 && known_pairs.size() != 0) begin
          pair   = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
          p.mass = pair[63:32];
        end
        p.softening = rand_positive();
        known_pairs.push_back({p.mass, p.softening});
      end else begin
        pair        = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
        p.mass      = pair[63:32];
        p.softening = pair[31:0];
      end
      case ($urandom_range(0, 19))
        0: begin
          p.order     = ORDER_W'({$urandom, $urandom});
          p.mass      = $urandom;
          p.softening = $urandom;
        end
        1: p.order = cfg_first - 1'b1;
        2: p.order = cfg_first + cfg_count;
        3: begin
          case ($urandom_range(0, 2))
            0: p.mass = $urandom | 32'h8000_0000;
            1: p.softening = {1'b0, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
            default: p.mass = 32'd0;
          endcase
        end
        default: ;
      endcase
      push_particle(p.order, p.mass, p.softening);
    end
  endtask

  // block idle: everything accepted and answered, then a short margin
  task automatic settle();
    while (particles_sent != particles_queued || predicted_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_FIRST) begin
      cfg_first = val[ORDER_W-1:0];
    end else begin
      cfg_count  = val[31:0];
      left_count = val[31:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold until the transaction completes
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (queued_particles.size() != 0) begin
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        in_gap = gap_len() - 1;
        in_tvalid <= 1'b0;
      end else begin
        cur_particle = queued_particles.pop_front();
        in_tdata  <= {cur_particle.softening, cur_particle.mass, cur_particle.order};
        in_tvalid <= 1'b1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      out_gap = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    class_tag_t want;
    bit         ok;
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took) begin
      predicted_tags.push_back(intern_particle(cur_particle));
      particles_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_tags.size() == 0) begin
        $error("result with nothing pending: tdata %h tuser %h", out_tdata, out_tuser);
        failed = 1'b1;
      end else begin
        want = predicted_tags.pop_front();
        ok   = field_ok("class_index", want.cls, out_tdata[7:0]);
        ok   = field_ok("local_index", want.local_idx, out_tdata[39:8]) && ok;
        ok   = field_ok("items_left", want.left, out_tdata[71:40]) && ok;
        ok   = field_ok("new_class", want.new_flag, out_tuser[0]) && ok;
        ok   = field_ok("error_code", want.err, out_tuser[3:1]) && ok;
        if (!ok) failed = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tbl_used    = 0;
    left_count  = '0;
    cfg_first   = '0;
    cfg_count   = '0;
    idle_pct    = 25;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // nothing expected after reset: everything is unexpected, even all-zero and all-one fields
    @(posedge clk);
    push_particle('0, '0, '0);
    push_particle(ORDER_TOP, '1, '1);
    settle();

    write_reg(REG_FIRST, 64'd1000);
    write_reg(REG_COUNT, 64'd12);
    @(posedge clk);
    push_particle(40'd999,  32'hBF80_0000, 32'h3DCC_CCCD); // below window beats bad sign
    push_particle(40'd1012, 32'h3F80_0000, 32'h3DCC_CCCD); // one past the window
    push_particle(40'd1000, 32'h8000_0000, 32'h3DCC_CCCD); // negative zero
    push_particle(40'd1000, 32'h0000_0000, 32'h3DCC_CCCD); // zero mass
    push_particle(40'd1000, 32'h7FC0_0000, 32'h3DCC_CCCD); // NaN mass
    push_particle(40'd1000, 32'h3F80_0000, 32'hBF80_0000); // negative softening
    push_particle(40'd1000, 32'h3F80_0000, 32'h7F80_0001); // NaN softening
    push_particle(40'd1005, 32'h3F80_0000, 32'h3DCC_CCCD); // new class
    push_particle(40'd1008, 32'h3F80_0000, 32'h3DCC_CCCD); // raises high
    push_particle(40'd1002, 32'h3F80_0000, 32'h3DCC_CCCD); // lowers low
    push_particle(40'd1006, 32'h3F80_0000, 32'h3DCC_CCCD); // inside range
    push_particle(40'd1000, 32'h7F80_0000, 32'h0000_0001); // infinity and denormal pass
    push_particle(40'd1011, 32'h0000_0001, 32'h7F7F_FFFF); // top of window
    push_particle(40'd1001, 32'h3F80_0000, 32'h3DCC_CCCE); // softening differs
    push_particle(40'd1003, 32'h3F80_0001, 32'h3DCC_CCCD); // mass differs
    push_particle(40'd1004, 32'h3F80_0000, 32'h3DCC_CCCD);
    push_particle(40'd1007, 32'h7F80_0000, 32'h0000_0001);
    push_particle(40'd1009, 32'h0000_0001, 32'h7F7F_FFFF);
    push_particle(40'd1010, 32'h3F80_0001, 32'h3DCC_CCCD); // count now exhausted
    push_particle(40'd1004, 32'h3F80_0000, 32'h3DCC_CCCD); // unexpected
    settle();

    write_reg(REG_FIRST, 64'(ORDER_W'({$urandom, $urandom}) >> 1));
    write_reg(REG_COUNT, 64'($urandom_range(140, 220)));
    queue_random(170, 35);
    settle();

    // widest window from zero; this phase mostly sends fresh mass and softening pairs
    write_reg(REG_FIRST, 64'd0);
    write_reg(REG_COUNT, 64'hFFFF_FFFF);
    queue_random(120, 95);
    settle();
    queue_random(120, 95);
    settle();

    // window pinned at the top order; no idling here
    write_reg(REG_FIRST, 64'(ORDER_TOP));
    idle_pct = 0;
    queue_random(80, 60);
    settle();

    idle_pct = 30;
    write_reg(REG_FIRST, 64'(ORDER_W'({$urandom, $urandom}) >> 2));
    write_reg(REG_COUNT, 64'd40);
    queue_random(60, 30);
    settle();

    repeat (20) @(posedge clk);
    if (!failed && predicted_tags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
